>>> design/bim_pkg.sv
// Shared constants for the broadcast index mapper: configuration register map and reset values.
`timescale 1ns / 1ps
`default_nettype none
package bim_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;
	localparam int DIM_COUNT_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DIM_COUNT   = 2'd0,
		REG_TARGET_DIMS = 2'd1,
		REG_SOURCE_DIMS = 2'd2
	} cfg_reg_t;

	localparam logic [DIM_COUNT_BITS-1:0] DIM_COUNT_RESET = 3'd1;
	localparam logic [CFG_DATA_BITS-1:0]  DIMS_RESET      = 64'h0001_0001_0001_0001;

endpackage
`default_nettype wire

>>> design/broadcast_index_mapper_top.sv
// Broadcast index mapper: target linear index to source linear index, fully pipelined.
//
// Item channel: item_valid / item_stall carry target_index. Result channel:
// result_valid / result_stall carry source_index, shape_error and
// index_out_of_range; one result per item, in order.
// Config: write cfg_data to register cfg_index when cfg_write_en is high
// (0 dim_count, 1 target dims, 2 source dims); only while the block is idle.
// Each dimension, innermost first, runs through INDEX_BITS restoring divide
// stages (one quotient bit per stage), a multiply stage and an accumulate
// stage. One item is taken per cycle while item_stall is low.
// After reset and after every config write, a setup pass over the dimensions
// derives divisors, source strides and the element count; item_stall is
// high during it. When result_stall is high while result_valid is high, the
// whole pipeline holds and item_stall goes high, so nothing is lost or repeated.
// Flags force source_index to zero.
`timescale 1ns / 1ps
`default_nettype none
module broadcast_index_mapper_top #(
	parameter int MAX_DIMS   = 4,
	parameter int DIM_BITS   = 16,
	parameter int INDEX_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic [INDEX_BITS-1:0]                target_index,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic [INDEX_BITS-1:0]                     source_index,
	output logic                                      shape_error,
	output logic                                      index_out_of_range,
	input  wire logic                                 cfg_write_en,
	input  wire logic [bim_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [bim_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int KB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int PW = MAX_DIMS * DIM_BITS + bim_pkg::CFG_DATA_BITS;
	localparam int CW = INDEX_BITS + DIM_BITS + 1;
	localparam logic [INDEX_BITS:0] CNT_MAX = {1'b1, {INDEX_BITS{1'b0}}};

	typedef struct packed {
		logic shape;
		logic range;
	} flags_t;

	// configuration registers
	logic [bim_pkg::DIM_COUNT_BITS-1:0] dim_count_q;
	logic [bim_pkg::CFG_DATA_BITS-1:0]  target_dims_q;
	logic [bim_pkg::CFG_DATA_BITS-1:0]  source_dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q   <= bim_pkg::DIM_COUNT_RESET;
			target_dims_q <= bim_pkg::DIMS_RESET;
			source_dims_q <= bim_pkg::DIMS_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				bim_pkg::REG_DIM_COUNT:
					dim_count_q <= cfg_data[bim_pkg::DIM_COUNT_BITS-1:0];
				bim_pkg::REG_TARGET_DIMS: target_dims_q <= cfg_data;
				bim_pkg::REG_SOURCE_DIMS: source_dims_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpacked sizes; fields past the register read as zero
	logic [PW-1:0]       tdim_ext, sdim_ext;
	logic [DIM_BITS-1:0] tdim [MAX_DIMS];
	logic [DIM_BITS-1:0] sdim [MAX_DIMS];
	logic                active [MAX_DIMS];
	logic [MAX_DIMS-1:0] dim_bad;

	assign tdim_ext = PW'(target_dims_q);
	assign sdim_ext = PW'(source_dims_q);

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_unpack
		assign tdim[d]   = tdim_ext[d*DIM_BITS +: DIM_BITS];
		assign sdim[d]   = sdim_ext[d*DIM_BITS +: DIM_BITS];
		// dim_count of zero acts as one; above MAX_DIMS saturates by itself
		assign active[d] = (d == 0) || (32'(d) < 32'(dim_count_q));
		assign dim_bad[d] = active[d] && ((tdim[d] == '0) || (sdim[d] == '0) ||
			((sdim[d] != DIM_BITS'(1)) && (sdim[d] != tdim[d])));
	end

	// setup pass, innermost dimension first
	logic                  busy_q;
	logic [KB-1:0]         k_q;
	logic [INDEX_BITS-1:0] st_q;
	logic [INDEX_BITS:0]   cnt_q;
	logic [DIM_BITS-1:0]   div_q [MAX_DIMS];
	logic [INDEX_BITS-1:0] eff_stride_q [MAX_DIMS];

	logic [DIM_BITS-1:0]   sel_t, sel_s;
	logic                  sel_act;
	logic [CW-1:0]         cnt_prod;
	logic [INDEX_BITS-1:0] st_prod;

	always_comb begin
		sel_t    = tdim[k_q];
		sel_s    = sdim[k_q];
		sel_act  = active[k_q];
		cnt_prod = CW'(cnt_q) * CW'(sel_t);
		st_prod  = st_q * INDEX_BITS'(sel_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			k_q    <= KB'(MAX_DIMS - 1);
			st_q   <= INDEX_BITS'(1);
			cnt_q  <= (INDEX_BITS+1)'(1);
		end else if (cfg_write_en) begin
			busy_q <= 1'b1;
			k_q    <= KB'(MAX_DIMS - 1);
			st_q   <= INDEX_BITS'(1);
			cnt_q  <= (INDEX_BITS+1)'(1);
		end else if (busy_q) begin
			if (sel_act) begin
				st_q  <= st_prod;
				cnt_q <= (cnt_prod > CW'(CNT_MAX)) ? CNT_MAX : cnt_prod[INDEX_BITS:0];
			end
			if (k_q == '0)
				busy_q <= 1'b0;
			else
				k_q <= k_q - KB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !cfg_write_en) begin
			div_q[k_q]        <= sel_act ? sel_t : DIM_BITS'(1);
			eff_stride_q[k_q] <= (sel_act && (sel_s != DIM_BITS'(1))) ? st_q : '0;
		end
	end

	// pipeline control: the whole pipe moves together
	logic adv;
	logic accept;

	assign adv        = !result_valid || !result_stall;
	assign item_stall = busy_q || !adv;
	assign accept     = item_valid && !item_stall;

	// entry stage
	logic                  v_s0;
	logic [INDEX_BITS-1:0] w_s0;
	flags_t                e_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s0 <= 1'b0;
		else if (adv)
			v_s0 <= accept;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s0       <= target_index;
			e_s0.shape <= |dim_bad;
			e_s0.range <= {1'b0, target_index} >= cnt_q;
		end
	end

	// per-dimension stages
	logic                  dv_v_s [MAX_DIMS][INDEX_BITS];
	logic [INDEX_BITS-1:0] dv_w_s [MAX_DIMS][INDEX_BITS];
	logic [DIM_BITS-1:0]   dv_r_s [MAX_DIMS][INDEX_BITS];
	logic [INDEX_BITS-1:0] dv_a_s [MAX_DIMS][INDEX_BITS];
	flags_t                dv_e_s [MAX_DIMS][INDEX_BITS];

	logic                  mu_v_s [MAX_DIMS];
	logic [INDEX_BITS-1:0] mu_w_s [MAX_DIMS];
	logic [INDEX_BITS-1:0] mu_p_s [MAX_DIMS];
	logic [INDEX_BITS-1:0] mu_a_s [MAX_DIMS];
	flags_t                mu_e_s [MAX_DIMS];

	logic                  ad_v_s [MAX_DIMS];
	logic [INDEX_BITS-1:0] ad_w_s [MAX_DIMS];
	logic [INDEX_BITS-1:0] ad_a_s [MAX_DIMS];
	flags_t                ad_e_s [MAX_DIMS];

	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
		// block g handles dimension MAX_DIMS-1-g
		localparam int D = MAX_DIMS - 1 - g;

		logic                  bv;
		logic [INDEX_BITS-1:0] bw;
		logic [INDEX_BITS-1:0] ba;
		flags_t                be;

		if (g == 0) begin : g_first
			assign bv = v_s0;
			assign bw = w_s0;
			assign ba = '0;
			assign be = e_s0;
		end else begin : g_next
			assign bv = ad_v_s[g-1];
			assign bw = ad_w_s[g-1];
			assign ba = ad_a_s[g-1];
			assign be = ad_e_s[g-1];
		end

		for (genvar b = 0; b < INDEX_BITS; b++) begin : g_bit
			logic                  iv;
			logic [INDEX_BITS-1:0] iw;
			logic [DIM_BITS-1:0]   ir;
			logic [INDEX_BITS-1:0] ia;
			flags_t                ie;
			logic [DIM_BITS:0]     t;
			logic [DIM_BITS:0]     dz;
			logic                  ge;

			if (b == 0) begin : g_head
				assign iv = bv;
				assign iw = bw;
				assign ir = '0;
				assign ia = ba;
				assign ie = be;
			end else begin : g_body
				assign iv = dv_v_s[g][b-1];
				assign iw = dv_w_s[g][b-1];
				assign ir = dv_r_s[g][b-1];
				assign ia = dv_a_s[g][b-1];
				assign ie = dv_e_s[g][b-1];
			end

			// one restoring step: quotient bits shift in where dividend bits leave
			assign t  = {ir, iw[INDEX_BITS-1]};
			assign dz = {1'b0, div_q[D]};
			assign ge = t >= dz;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_v_s[g][b] <= 1'b0;
				else if (adv)
					dv_v_s[g][b] <= iv;
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_w_s[g][b] <= {iw[INDEX_BITS-2:0], ge};
					dv_r_s[g][b] <= ge ? DIM_BITS'(t - dz) : DIM_BITS'(t);
					dv_a_s[g][b] <= ia;
					dv_e_s[g][b] <= ie;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mu_v_s[g] <= 1'b0;
				ad_v_s[g] <= 1'b0;
			end else if (adv) begin
				mu_v_s[g] <= dv_v_s[g][INDEX_BITS-1];
				ad_v_s[g] <= mu_v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mu_w_s[g] <= dv_w_s[g][INDEX_BITS-1];
				mu_p_s[g] <= INDEX_BITS'(dv_r_s[g][INDEX_BITS-1]) * eff_stride_q[D];
				mu_a_s[g] <= dv_a_s[g][INDEX_BITS-1];
				mu_e_s[g] <= dv_e_s[g][INDEX_BITS-1];
				ad_w_s[g] <= mu_w_s[g];
				ad_a_s[g] <= (mu_e_s[g].shape || mu_e_s[g].range) ? '0 :
					mu_a_s[g] + mu_p_s[g];
				ad_e_s[g] <= mu_e_s[g];
			end
		end
	end

	assign result_valid       = ad_v_s[MAX_DIMS-1];
	assign source_index       = ad_a_s[MAX_DIMS-1];
	assign shape_error        = ad_e_s[MAX_DIMS-1].shape;
	assign index_out_of_range = ad_e_s[MAX_DIMS-1].range;

endmodule
`default_nettype wire
